>>> hdl/wudu_pkg.sv
package wudu_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int EPS_W     = 16;
    localparam int WIDE_W    = 38;                  // stencil sums, +-20 * 2^31
    localparam int MAG_W     = 31;                  // clamped difference magnitude
    localparam int SQ_FRAC   = 24;
    localparam int SQ_W      = 2 * MAG_W - SQ_FRAC; // 38
    localparam int IND_W     = SQ_W + 4;            // 13*sp + 3*sq
    localparam int HALF_W    = 36;                  // (|cand| + 3) / 2
    localparam int D3_W      = 40;
    localparam int D3_CHUNK  = 8;
    localparam int D3_STAGES = D3_W / D3_CHUNK;
    localparam int T_W       = 40;
    localparam int R_STEPS   = 14;                  // quotient bits of tmin * 2^13 / t
    localparam int RR_W      = 27;
    localparam int V_W       = RR_W + 2;
    localparam int F_W       = 35;
    localparam int NUM_W     = 64;
    localparam int DEN_W     = V_W + 1;
    localparam int M_W       = NUM_W - 1;
    localparam int Q_STEPS   = 34;
    localparam int DIFF_W    = F_W + 1;

    localparam int FACE_LAT  = 3 + D3_STAGES + 2 + R_STEPS + 5 + Q_STEPS + 1;
    localparam int PIPE_LEN  = FACE_LAT + 2;

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd17;
    localparam logic [MAG_W-1:0] MAG_MAX   = '1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [WIDE_W-1:0]   t_wide;
    typedef logic [MAG_W-1:0]           t_mag;
    typedef logic [2*MAG_W-1:0]         t_sqfull;
    typedef logic [SQ_W-1:0]            t_sq;
    typedef logic [IND_W-1:0]           t_ind;
    typedef logic [HALF_W-1:0]          t_half;
    typedef logic [D3_W-1:0]            t_d3;
    typedef logic [T_W-1:0]             t_tval;
    typedef logic [T_W:0]               t_tx;
    typedef logic [R_STEPS-1:0]         t_rel;
    typedef logic [2*R_STEPS-1:0]       t_relsq;
    typedef logic [RR_W-1:0]            t_rr;
    typedef logic [V_W-1:0]             t_v;
    typedef logic signed [F_W-1:0]      t_f;
    typedef logic signed [NUM_W-1:0]    t_num;
    typedef logic [DEN_W-1:0]           t_den;
    typedef logic [DEN_W:0]             t_denx;
    typedef logic [M_W-1:0]             t_mnum;
    typedef logic [Q_STEPS-1:0]         t_qw;
    typedef logic signed [DIFF_W-1:0]   t_diff;

    // Eight bits of a long division by three; returns {remainder, quotient}.
    function automatic logic [D3_CHUNK+1:0] div3_step(input logic [1:0] rem_in,
                                                      input logic [D3_CHUNK-1:0] din);
        logic [1:0]          rem;
        logic [2:0]          acc;
        logic [D3_CHUNK-1:0] q;
        rem = rem_in;
        for (int i = D3_CHUNK - 1; i >= 0; i--) begin
            acc  = {rem, din[i]};
            q[i] = (acc >= 3'd3);
            rem  = q[i] ? 2'(acc - 3'd3) : acc[1:0];
        end
        return {rem, q};
    endfunction

endpackage

>>> hdl/wudu_face.sv
module wudu_face (
    input  logic                          i_clk,
    input  logic                          i_plus,
    input  logic [wudu_pkg::EPS_W-1:0]    i_eps,
    input  wudu_pkg::t_sample             i_a,
    input  wudu_pkg::t_sample             i_b,
    input  wudu_pkg::t_sample             i_c,
    input  wudu_pkg::t_sample             i_d,
    input  wudu_pkg::t_sample             i_e,
    output wudu_pkg::t_f                  o_face
);

    // abs, clamp to 2^31-1
    function automatic wudu_pkg::t_mag clamp_mag(input wudu_pkg::t_wide x);
        wudu_pkg::t_wide m;
        m = x[wudu_pkg::WIDE_W-1] ? -x : x;
        return (m > wudu_pkg::t_wide'(wudu_pkg::MAG_MAX)) ? wudu_pkg::MAG_MAX
                                                          : m[wudu_pkg::MAG_W-1:0];
    endfunction

    // ---- stage 1: differences and candidates
    wudu_pkg::t_wide a, b, c, d, e;
    wudu_pkg::t_wide n_dif [6];
    wudu_pkg::t_wide n_cand [3];
    wudu_pkg::t_wide cabs;
    wudu_pkg::t_mag  r1_mag [6];
    logic [2:0]      r1_neg;
    wudu_pkg::t_half r1_half [3];
    logic            r1_plus;

    always_comb begin
        a = wudu_pkg::t_wide'(i_a);
        b = wudu_pkg::t_wide'(i_b);
        c = wudu_pkg::t_wide'(i_c);
        d = wudu_pkg::t_wide'(i_d);
        e = wudu_pkg::t_wide'(i_e);
        n_dif[0] = a + c - 2 * b;
        n_dif[1] = b + d - 2 * c;
        n_dif[2] = c + e - 2 * d;
        n_dif[3] = a + 3 * c - 4 * b;
        n_dif[4] = b - d;
        n_dif[5] = 3 * c + e - 4 * d;
        if (i_plus) begin
            n_cand[0] = 11 * c + 2 * a - 7 * b;
            n_cand[1] = 5 * c - b + 2 * d;
            n_cand[2] = 2 * c + 5 * d - e;
        end else begin
            n_cand[0] = 2 * c - a + 5 * b;
            n_cand[1] = 5 * c + 2 * b - d;
            n_cand[2] = 11 * c - 7 * d + 2 * e;
        end
        cabs = '0;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r1_mag[k] <= clamp_mag(n_dif[k]);
        end
        for (int k = 0; k < 3; k++) begin
            r1_neg[k]  <= n_cand[k][wudu_pkg::WIDE_W-1];
            r1_half[k] <= wudu_pkg::t_half'(((n_cand[k][wudu_pkg::WIDE_W-1] ? -n_cand[k]
                                                : n_cand[k]) + 3 + cabs) >>> 1);
        end
        r1_plus <= i_plus;
    end

    // ---- stage 2: squares, Q24
    wudu_pkg::t_sqfull n_sqf [6];
    wudu_pkg::t_sq     r2_sq [6];
    logic [2:0]        r2_neg;
    wudu_pkg::t_half   r2_half [3];
    logic              r2_plus;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            n_sqf[k] = wudu_pkg::t_sqfull'(r1_mag[k]) * wudu_pkg::t_sqfull'(r1_mag[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r2_sq[k] <= n_sqf[k][2*wudu_pkg::MAG_W-1:wudu_pkg::SQ_FRAC];
        end
        r2_neg  <= r1_neg;
        r2_half <= r1_half;
        r2_plus <= r1_plus;
    end

    // ---- stage 3: 13*sp + 3*sq, then /4
    wudu_pkg::t_ind  n_ind [3];
    wudu_pkg::t_d3   r3_ind4 [3];
    logic [2:0]      r3_neg;
    wudu_pkg::t_half r3_half [3];
    logic            r3_plus;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ind[k] = wudu_pkg::t_ind'(r2_sq[k]) * wudu_pkg::t_ind'(13)
                     + wudu_pkg::t_ind'(r2_sq[k+3]) * wudu_pkg::t_ind'(3);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r3_ind4[k] <= n_ind[k][wudu_pkg::IND_W-1:2];
        end
        r3_neg  <= r2_neg;
        r3_half <= r2_half;
        r3_plus <= r2_plus;
    end

    // ---- stages 4..8: divide by three, one byte per stage
    wudu_pkg::t_d3             n_dq   [wudu_pkg::D3_STAGES][6];
    logic [1:0]                n_drem [wudu_pkg::D3_STAGES][6];
    wudu_pkg::t_d3             r_dq   [wudu_pkg::D3_STAGES][6];
    logic [1:0]                r_drem [wudu_pkg::D3_STAGES-1][6];
    logic [2:0]                r_dneg [wudu_pkg::D3_STAGES];
    logic                      r_dplus[wudu_pkg::D3_STAGES];
    logic [wudu_pkg::D3_CHUNK+1:0] d3_tmp;

    always_comb begin
        d3_tmp = '0;
        for (int k = 0; k < 6; k++) begin
            n_dq[0][k] = (k < 3) ? r3_ind4[k % 3] : wudu_pkg::t_d3'(r3_half[k % 3]);
            d3_tmp = wudu_pkg::div3_step(2'd0,
                         n_dq[0][k][wudu_pkg::D3_W-1 -: wudu_pkg::D3_CHUNK]);
            n_dq[0][k][wudu_pkg::D3_W-1 -: wudu_pkg::D3_CHUNK] =
                d3_tmp[wudu_pkg::D3_CHUNK-1:0];
            n_drem[0][k] = d3_tmp[wudu_pkg::D3_CHUNK+1:wudu_pkg::D3_CHUNK];
        end
        for (int j = 1; j < wudu_pkg::D3_STAGES; j++) begin
            for (int k = 0; k < 6; k++) begin
                n_dq[j][k] = r_dq[j-1][k];
                d3_tmp = wudu_pkg::div3_step(r_drem[j-1][k],
                    r_dq[j-1][k][wudu_pkg::D3_W-1-wudu_pkg::D3_CHUNK*j -: wudu_pkg::D3_CHUNK]);
                n_dq[j][k][wudu_pkg::D3_W-1-wudu_pkg::D3_CHUNK*j -: wudu_pkg::D3_CHUNK] =
                    d3_tmp[wudu_pkg::D3_CHUNK-1:0];
                n_drem[j][k] = d3_tmp[wudu_pkg::D3_CHUNK+1:wudu_pkg::D3_CHUNK];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < wudu_pkg::D3_STAGES; j++) begin
            for (int k = 0; k < 6; k++) begin
                r_dq[j][k] <= n_dq[j][k];
                if (j < wudu_pkg::D3_STAGES - 1) begin
                    r_drem[j][k] <= n_drem[j][k];
                end
            end
            r_dneg[j]  <= (j == 0) ? r3_neg  : r_dneg[j-1];
            r_dplus[j] <= (j == 0) ? r3_plus : r_dplus[j-1];
        end
    end

    // ---- stage 9: t = b + eps (never zero), signed candidates
    wudu_pkg::t_tval n_t [3];
    wudu_pkg::t_f    n_f [3];
    wudu_pkg::t_tval r9_t [3];
    wudu_pkg::t_f    r9_f [3];
    logic            r9_plus;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_t[k] = r_dq[wudu_pkg::D3_STAGES-1][k] + wudu_pkg::t_tval'(i_eps);
            if (n_t[k] == '0) begin
                n_t[k] = wudu_pkg::t_tval'(1);
            end
            n_f[k] = signed'({1'b0, r_dq[wudu_pkg::D3_STAGES-1][k+3][wudu_pkg::F_W-2:0]});
            if (r_dneg[wudu_pkg::D3_STAGES-1][k]) begin
                n_f[k] = -n_f[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r9_t    <= n_t;
        r9_f    <= n_f;
        r9_plus <= r_dplus[wudu_pkg::D3_STAGES-1];
    end

    // ---- stage 10: smallest t
    wudu_pkg::t_tval n_tmin;
    wudu_pkg::t_tval r10_tmin;
    wudu_pkg::t_tval r10_t [3];
    wudu_pkg::t_f    r10_f [3];
    logic            r10_plus;

    always_comb begin
        n_tmin = r9_t[0];
        if (r9_t[1] < n_tmin) begin
            n_tmin = r9_t[1];
        end
        if (r9_t[2] < n_tmin) begin
            n_tmin = r9_t[2];
        end
    end

    always_ff @(posedge i_clk) begin
        r10_tmin <= n_tmin;
        r10_t    <= r9_t;
        r10_f    <= r9_f;
        r10_plus <= r9_plus;
    end

    // ---- stages 11..24: r = tmin * 2^13 / t, one quotient bit per stage
    localparam int RS = wudu_pkg::R_STEPS;
    wudu_pkg::t_tx   rx_rem2;
    logic            rx_bit;
    wudu_pkg::t_tval n_rrem [RS][3];
    wudu_pkg::t_rel  n_rq   [RS][3];
    wudu_pkg::t_tval r_rrem [RS-1][3];
    wudu_pkg::t_tval r_rt   [RS-1][3];
    wudu_pkg::t_rel  r_rq   [RS][3];
    wudu_pkg::t_f    r_rf   [RS][3];
    logic            r_rplus[RS];

    always_comb begin
        rx_rem2 = '0;
        rx_bit  = 1'b0;
        for (int k = 0; k < 3; k++) begin
            rx_rem2 = {1'b0, r10_tmin};
            rx_bit  = (rx_rem2 >= {1'b0, r10_t[k]});
            n_rrem[0][k] = rx_bit ? wudu_pkg::t_tval'(rx_rem2 - {1'b0, r10_t[k]})
                                  : wudu_pkg::t_tval'(rx_rem2);
            n_rq[0][k]   = wudu_pkg::t_rel'(rx_bit);
        end
        for (int j = 1; j < RS; j++) begin
            for (int k = 0; k < 3; k++) begin
                rx_rem2 = {r_rrem[j-1][k], 1'b0};
                rx_bit  = (rx_rem2 >= {1'b0, r_rt[j-1][k]});
                n_rrem[j][k] = rx_bit ? wudu_pkg::t_tval'(rx_rem2 - {1'b0, r_rt[j-1][k]})
                                      : wudu_pkg::t_tval'(rx_rem2);
                n_rq[j][k]   = {r_rq[j-1][k][RS-2:0], rx_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < RS; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (j < RS - 1) begin
                    r_rrem[j][k] <= n_rrem[j][k];
                    r_rt[j][k]   <= (j == 0) ? r10_t[k] : r_rt[j-1][k];
                end
                r_rq[j][k] <= n_rq[j][k];
                r_rf[j][k] <= (j == 0) ? r10_f[k] : r_rf[j-1][k];
            end
            r_rplus[j] <= (j == 0) ? r10_plus : r_rplus[j-1];
        end
    end

    // ---- stage 25: r^2
    wudu_pkg::t_relsq n_rsq [3];
    wudu_pkg::t_rr    r25_rr [3];
    wudu_pkg::t_f     r25_f [3];
    logic             r25_plus;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_rsq[k] = wudu_pkg::t_relsq'(r_rq[RS-1][k]) * wudu_pkg::t_relsq'(r_rq[RS-1][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r25_rr[k] <= n_rsq[k][wudu_pkg::RR_W-1:0];
        end
        r25_f    <= r_rf[RS-1];
        r25_plus <= r_rplus[RS-1];
    end

    // ---- stage 26: v = g * r^2, g in tenths
    wudu_pkg::t_v x1 [3];
    wudu_pkg::t_v x3 [3];
    wudu_pkg::t_v r26_v [3];
    wudu_pkg::t_f r26_f [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            x1[k] = wudu_pkg::t_v'(r25_rr[k]);
            x3[k] = x1[k] + (x1[k] << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        r26_v[0] <= r25_plus ? x1[0] : x3[0];
        r26_v[1] <= x3[1] << 1;
        r26_v[2] <= r25_plus ? x3[2] : x1[2];
        r26_f    <= r25_f;
    end

    // ---- stage 27: v * f and the sum of v
    wudu_pkg::t_num r27_prod [3];
    wudu_pkg::t_den r27_den;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r27_prod[k] <= wudu_pkg::t_num'(signed'({1'b0, r26_v[k]}))
                         * wudu_pkg::t_num'(r26_f[k]);
        end
        r27_den <= wudu_pkg::t_den'(r26_v[0]) + wudu_pkg::t_den'(r26_v[1])
                 + wudu_pkg::t_den'(r26_v[2]);
    end

    // ---- stage 28: numerator sum
    wudu_pkg::t_num r28_num;
    wudu_pkg::t_den r28_den;

    always_ff @(posedge i_clk) begin
        r28_num <= r27_prod[0] + r27_prod[1] + r27_prod[2];
        r28_den <= r27_den;
    end

    // ---- stage 29: |num| + den/2 for round half away from zero
    wudu_pkg::t_num n_abs;
    wudu_pkg::t_mnum r29_m;
    wudu_pkg::t_den  r29_den;
    logic            r29_neg;

    always_comb begin
        n_abs = r28_num[wudu_pkg::NUM_W-1] ? -r28_num : r28_num;
    end

    always_ff @(posedge i_clk) begin
        r29_m   <= n_abs[wudu_pkg::M_W-1:0] + wudu_pkg::t_mnum'(r28_den >> 1);
        r29_den <= r28_den;
        r29_neg <= r28_num[wudu_pkg::NUM_W-1];
    end

    // ---- stages 30..63: restoring division, one bit per stage
    localparam int QS = wudu_pkg::Q_STEPS;
    wudu_pkg::t_denx qx_rem2;
    logic            qx_bit;
    wudu_pkg::t_den  n_qrem [QS];
    wudu_pkg::t_qw   n_qw   [QS];
    wudu_pkg::t_den  r_qrem [QS-1];
    wudu_pkg::t_den  r_qden [QS-1];
    wudu_pkg::t_qw   r_qw   [QS];
    logic            r_qneg [QS];

    always_comb begin
        qx_rem2   = {1'b0, r29_m[wudu_pkg::M_W-1:QS], r29_m[QS-1]};
        qx_bit    = (qx_rem2 >= {1'b0, r29_den});
        n_qrem[0] = qx_bit ? wudu_pkg::t_den'(qx_rem2 - {1'b0, r29_den})
                           : wudu_pkg::t_den'(qx_rem2);
        n_qw[0]   = {r29_m[QS-2:0], qx_bit};
        for (int j = 1; j < QS; j++) begin
            qx_rem2   = {r_qrem[j-1], r_qw[j-1][QS-1]};
            qx_bit    = (qx_rem2 >= {1'b0, r_qden[j-1]});
            n_qrem[j] = qx_bit ? wudu_pkg::t_den'(qx_rem2 - {1'b0, r_qden[j-1]})
                               : wudu_pkg::t_den'(qx_rem2);
            n_qw[j]   = {r_qw[j-1][QS-2:0], qx_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < QS; j++) begin
            if (j < QS - 1) begin
                r_qrem[j] <= n_qrem[j];
                r_qden[j] <= (j == 0) ? r29_den : r_qden[j-1];
            end
            r_qw[j]   <= n_qw[j];
            r_qneg[j] <= (j == 0) ? r29_neg : r_qneg[j-1];
        end
    end

    // ---- stage 64: apply sign
    wudu_pkg::t_f n_face;
    wudu_pkg::t_f r_face;

    always_comb begin
        n_face = signed'({1'b0, r_qw[QS-1]});
        if (r_qneg[QS-1]) begin
            n_face = -n_face;
        end
    end

    always_ff @(posedge i_clk) begin
        r_face <= n_face;
    end

    assign o_face = r_face;

endmodule

>>> hdl/weno5_upwind_difference_unit.sv
// Channel    | Direction | Handshake                      | Payload
// -----------+-----------+--------------------------------+--------------------------------
// item       | in        | start & !busy                  | i_velocity, i_sample_m3..p3
// result     | out       | o_strobe, one cycle, no stall  | o_face_difference, o_saturated
// config     | in        | i_cfg_valid & o_cfg_ready      | i_cfg_data (smoothness eps)
//
// One transaction per cycle is accepted; busy stays low, the pipeline never stalls.
// The path is the input register, 64 face stages and the output register. The face
// stages are dominated by the two bit-serial dividers (14 stages for the relative
// inverse, 34 for the final blend division) and a 5-stage divide-by-three.
// Reset clears the valid chain and loads eps = 17; data registers are not reset.
// Eps should only be written while no transaction is in flight.
module weno5_upwind_difference_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [wudu_pkg::EPS_W-1:0] i_cfg_data,
    input  wudu_pkg::t_sample          i_velocity,
    input  wudu_pkg::t_sample          i_sample_m3,
    input  wudu_pkg::t_sample          i_sample_m2,
    input  wudu_pkg::t_sample          i_sample_m1,
    input  wudu_pkg::t_sample          i_sample_center,
    input  wudu_pkg::t_sample          i_sample_p1,
    input  wudu_pkg::t_sample          i_sample_p2,
    input  wudu_pkg::t_sample          i_sample_p3,
    output logic                       o_strobe,
    output wudu_pkg::t_sample          o_face_difference,
    output logic                       o_saturated
);

    // Config register: always ready.
    logic [wudu_pkg::EPS_W-1:0] r_eps;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= wudu_pkg::EPS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_eps <= i_cfg_data;
        end
    end

    // Fully pipelined, no back-pressure.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits travel alongside the data.
    logic [wudu_pkg::PIPE_LEN-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[wudu_pkg::PIPE_LEN-2:0], accept};
        end
    end

    // Stage 0: upwind direction picks the stencil windows. Zero velocity
    // goes right-biased.
    logic              r_plus;
    wudu_pkg::t_sample r_ra, r_rb, r_rc, r_rd, r_re;
    wudu_pkg::t_sample r_la, r_lb, r_lc, r_ld, r_le;

    always_ff @(posedge i_clk) begin
        if (i_velocity > 0) begin
            r_ra <= i_sample_m2; r_rb <= i_sample_m1; r_rc <= i_sample_center;
            r_rd <= i_sample_p1; r_re <= i_sample_p2;
            r_la <= i_sample_m3; r_lb <= i_sample_m2; r_lc <= i_sample_m1;
            r_ld <= i_sample_center; r_le <= i_sample_p1;
        end else begin
            r_ra <= i_sample_m1; r_rb <= i_sample_center; r_rc <= i_sample_p1;
            r_rd <= i_sample_p2; r_re <= i_sample_p3;
            r_la <= i_sample_m2; r_lb <= i_sample_m1; r_lc <= i_sample_center;
            r_ld <= i_sample_p1; r_le <= i_sample_p2;
        end
        r_plus <= (i_velocity > 0);
    end

    wudu_pkg::t_f face_r, face_l;

    wudu_face u_face_r (
        .i_clk  (i_clk),
        .i_plus (r_plus),
        .i_eps  (r_eps),
        .i_a    (r_ra),
        .i_b    (r_rb),
        .i_c    (r_rc),
        .i_d    (r_rd),
        .i_e    (r_re),
        .o_face (face_r)
    );

    wudu_face u_face_l (
        .i_clk  (i_clk),
        .i_plus (r_plus),
        .i_eps  (r_eps),
        .i_a    (r_la),
        .i_b    (r_lb),
        .i_c    (r_lc),
        .i_d    (r_ld),
        .i_e    (r_le),
        .o_face (face_l)
    );

    // Output stage: right minus left, saturated to 32 bits.
    wudu_pkg::t_diff   n_diff;
    logic              n_sat;
    wudu_pkg::t_sample n_out;
    wudu_pkg::t_sample r_out;
    logic              r_sat;

    always_comb begin
        n_diff = wudu_pkg::t_diff'(face_r) - wudu_pkg::t_diff'(face_l);
        n_sat  = 1'b1;
        if (n_diff > wudu_pkg::t_diff'(32'sh7FFF_FFFF)) begin
            n_out = 32'sh7FFF_FFFF;
        end else if (n_diff < wudu_pkg::t_diff'(32'sh8000_0000)) begin
            n_out = 32'sh8000_0000;
        end else begin
            n_out = n_diff[wudu_pkg::SAMPLE_W-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sat <= n_sat;
    end

    assign o_strobe          = r_vld[wudu_pkg::PIPE_LEN-1];
    assign o_face_difference = r_out;
    assign o_saturated       = r_sat;

endmodule

>>> test/tb_weno5_upwind_difference_unit.sv
`timescale 1ns / 100ps

// Holds predicted face differences in order and checks each strobed result.
class face_diff_board;
    logic signed [31:0] exp_diff[$];
    logic               exp_sat[$];
    int                 errors;
    int                 checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function void note_item(logic signed [31:0] diff, logic sat);
        exp_diff.push_back(diff);
        exp_sat.push_back(sat);
    endfunction

    function void check_result(logic signed [31:0] diff, logic sat);
        logic signed [31:0] ed;
        logic               es;
        if (exp_diff.size() == 0) begin
            $error("face_difference: unexpected result %0d", diff);
            errors++;
            return;
        end
        ed = exp_diff.pop_front();
        es = exp_sat.pop_front();
        checked++;
        if (diff !== ed) begin
            $error("face_difference: expected %0d actual %0d", ed, diff);
            errors++;
        end
        if (sat !== es) begin
            $error("saturated: expected %0d actual %0d", es, sat);
            errors++;
        end
    endfunction

    function int pending();
        return exp_diff.size();
    endfunction
endclass

module tb_weno5_upwind_difference_unit;
    typedef wudu_pkg::t_sample t_sample;

    localparam int LATENCY   = 66;
    localparam int WATCHDOG  = 2000;
    localparam int N_RANDOM  = 1530;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    logic           i_cfg_valid = 1'b0;
    logic           o_cfg_ready;
    logic [15:0]    i_cfg_data = '0;
    t_sample        i_velocity = '0;
    t_sample        i_sample_m3 = '0, i_sample_m2 = '0, i_sample_m1 = '0;
    t_sample        i_sample_center = '0;
    t_sample        i_sample_p1 = '0, i_sample_p2 = '0, i_sample_p3 = '0;
    logic           o_strobe;
    t_sample        o_face_difference;
    logic           o_saturated;

    face_diff_board board;
    logic [15:0]    eps_model;       // shadow copy of the epsilon register
    int             idle_cycles;     // cycles since the last accepted transaction, result, eps write or reset
    int             n_items;

    always #2 i_clk = ~i_clk;

    weno5_upwind_difference_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_velocity(i_velocity), .i_sample_m3(i_sample_m3), .i_sample_m2(i_sample_m2),
        .i_sample_m1(i_sample_m1), .i_sample_center(i_sample_center),
        .i_sample_p1(i_sample_p1), .i_sample_p2(i_sample_p2), .i_sample_p3(i_sample_p3),
        .o_strobe(o_strobe), .o_face_difference(o_face_difference),
        .o_saturated(o_saturated)
    );

    // ---------------- predictor ----------------
    // Rounded division, half away from zero; d is positive.
    function automatic longint rnd_div(longint n, longint d);
        longint unsigned mag, q;
        mag = (n < 0) ? longint'(-n) : n;
        q   = (mag + longint'(d) / 2) / longint'(d);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Clamp a smoothness difference to 31 bits, square it, drop 24 fraction bits.
    function automatic longint unsigned sq_term(longint x);
        longint unsigned s;
        if (x > 64'sd2147483647)  x = 64'sd2147483647;
        if (x < -64'sd2147483647) x = -64'sd2147483647;
        s = longint'(x * x);
        return s >> 24;
    endfunction

    function automatic longint unsigned smooth_ind(longint p, longint q);
        return (13 * sq_term(p) + 3 * sq_term(q)) / 12;
    endfunction

    // One WENO5 face from five samples; left_biased picks weights 0.1/0.6/0.3.
    function automatic longint weno_face(bit left_biased, longint a, longint b,
                                         longint c, longint d, longint e);
        longint unsigned t[3];
        longint          cand[3];
        longint          gw[3];
        longint unsigned tmin;
        longint          r, v, num, den;
        num = 0;
        den = 0;
        t[0] = smooth_ind(a + c - 2 * b, a + 3 * c - 4 * b);
        t[1] = smooth_ind(b + d - 2 * c, b - d);
        t[2] = smooth_ind(c + e - 2 * d, 3 * c + e - 4 * d);
        if (left_biased) begin
            gw = '{1, 6, 3};
            cand[0] = rnd_div(11 * c + 2 * a - 7 * b, 6);
            cand[1] = rnd_div(5 * c - b + 2 * d, 6);
            cand[2] = rnd_div(2 * c + 5 * d - e, 6);
        end else begin
            gw = '{3, 6, 1};
            cand[0] = rnd_div(2 * c - a + 5 * b, 6);
            cand[1] = rnd_div(5 * c + 2 * b - d, 6);
            cand[2] = rnd_div(11 * c - 7 * d + 2 * e, 6);
        end
        for (int k = 0; k < 3; k++) begin
            t[k] += eps_model;
            if (t[k] == 0) t[k] = 1;   // zero denominator guard
        end
        tmin = t[0];
        if (t[1] < tmin) tmin = t[1];
        if (t[2] < tmin) tmin = t[2];
        for (int k = 0; k < 3; k++) begin
            r   = longint'((tmin << 13) / t[k]);
            v   = gw[k] * r * r;
            num += v * cand[k];
            den += v;
        end
        return rnd_div(num, den);
    endfunction

    // ---------------- drivers ----------------
    // Wait a number of cycles before the next transaction.
    task automatic idle_wait(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_eps(logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        eps_model = value;
    endtask

    // Drain: wait for all expected results, then the pipeline depth so nothing is in flight.
    task automatic drain();
        while (board.pending() != 0) @(posedge i_clk);
        idle_wait(LATENCY + 4);
    endtask

    task automatic send_stencil(t_sample vel, t_sample m3, t_sample m2, t_sample m1,
                                t_sample c, t_sample p1, t_sample p2, t_sample p3,
                                int gap);
        longint fr, fl, diff;
        logic   sat;
        if (gap > 0) begin
            start <= 1'b0;
            idle_wait(gap);
        end
        start           <= 1'b1;
        i_velocity      <= vel;
        i_sample_m3     <= m3;
        i_sample_m2     <= m2;
        i_sample_m1     <= m1;
        i_sample_center <= c;
        i_sample_p1     <= p1;
        i_sample_p2     <= p2;
        i_sample_p3     <= p3;
        do @(posedge i_clk); while (busy);
        // positive velocity: left-biased; zero or negative: right-biased
        if (vel > 0) begin
            fr = weno_face(1'b1, m2, m1, c, p1, p2);
            fl = weno_face(1'b1, m3, m2, m1, c, p1);
        end else begin
            fr = weno_face(1'b0, m1, c, p1, p2, p3);
            fl = weno_face(1'b0, m2, m1, c, p1, p2);
        end
        diff = fr - fl;
        sat  = 1'b0;
        if (diff > 64'sd2147483647)  begin diff = 64'sd2147483647;  sat = 1'b1; end
        if (diff < -64'sd2147483648) begin diff = -64'sd2147483648; sat = 1'b1; end
        board.note_item(diff[31:0], sat);
        n_items++;
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_sample rand_sample(int mode);
        case (mode)
            0: return $urandom();
            1: return t_sample'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            2: return t_sample'($urandom_range(0, 2048)) - 1024;
            default: return ($urandom_range(0, 1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
    endfunction

    // Random stencil: smooth around a base value, or noisy with each sample full-range, mid, small or extreme.
    task automatic send_random(int gap);
        t_sample s[7];
        t_sample base, slope;
        int      mode;
        mode = $urandom_range(0, 9);
        if (mode < 5) begin
            base  = rand_sample(1);
            slope = t_sample'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            for (int k = 0; k < 7; k++)
                s[k] = base + slope * (k - 3) + (t_sample'($urandom_range(0, 511)) - 256);
        end else begin
            for (int k = 0; k < 7; k++) s[k] = rand_sample($urandom_range(0, 3));
        end
        send_stencil(rand_sample($urandom_range(0, 3)), s[0], s[1], s[2], s[3],
                     s[4], s[5], s[6], gap);
    endtask

    // Gap: random outside bursts, zero inside them for stretches of back-to-back transactions.
    function automatic int pick_gap(bit burst);
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // ---------------- result checking and watchdog ----------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_result(o_face_difference, o_saturated);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("watchdog expired with %0d results outstanding", board.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        logic [15:0] eps_set[5];
        bit          burst;
        board       = new();
        eps_model   = 16'd17;
        idle_cycles = 0;
        n_items     = 0;
        eps_set     = '{16'd1, 16'd65535, 16'd0, 16'd17, 16'd300};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset epsilon, field extremes, both directions, zero velocity,
        // flat stencils (zero indicators), huge differences that clamp, saturation.
        send_stencil(32'sd1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_stencil(32'sd0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_stencil(-32'sd1, 1, 2, 3, 4, 5, 6, 7, 0);
        send_stencil(32'sh7FFF_FFFF, 1, 2, 3, 4, 5, 6, 7, 0);
        send_stencil(32'sh8000_0000, -7, -6, -5, -4, -3, -2, -1, 1);
        send_stencil(32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_stencil(32'sd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_stencil(32'sd1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 2);
        send_stencil(-32'sd5, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        send_stencil(32'sd1, -1, -1, -1, -1, -1, -1, -1, 0);
        send_stencil(32'sd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                     32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
        end_burst();
        drain();

        // Zero epsilon with flat data exercises the zero-denominator guard.
        write_eps(16'd0);
        send_stencil(32'sd1, 5, 5, 5, 5, 5, 5, 5, 0);
        send_stencil(32'sd0, 5, 5, 5, 5, 5, 5, 5, 0);
        send_stencil(32'sd3, 0, 0, 0, 1 << 24, 0, 0, 0, 3);
        end_burst();
        drain();
        write_eps(16'd65535);
        send_stencil(32'sd1, 0, 1 << 20, 2 << 20, 3 << 20, 4 << 20, 5 << 20, 6 << 20, 0);
        send_stencil(-32'sd1, 0, 1 << 20, 2 << 20, 3 << 20, 4 << 20, 5 << 20, 6 << 20, 0);
        end_burst();
        drain();

        // Random phases over several epsilon settings; each phase ends with a drain,
        // which also gives the sender a pause until every result has come.
        for (int ph = 0; ph < 5; ph++) begin
            write_eps((ph == 4) ? 16'($urandom_range(1, 65535)) : eps_set[ph]);
            burst = 1'b0;
            for (int i = 0; i < N_RANDOM / 5; i++) begin
                if ($urandom_range(0, 39) == 0) burst = ~burst;
                send_random(pick_gap(burst));
            end
            end_burst();
            drain();
        end

        $display("covered %0d stencils, %0d results checked, eps extremes and zero",
                 n_items, board.checked);
        $display("both upwind directions, zero velocity, clamped and saturated cases");
        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
